// File: sv/assert_macros.svh
// Assertion macros for the checker file.
// Plain property wrappers with an error report.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

// File: sv/fcpu_pkg.sv
// Package for the fly camera pose block: mode codes, register indexes, widths.
// No dependencies.
`timescale 1ns / 1ps
package fcpu_pkg;
	localparam logic [3:0] MODE_FRONT = 4'd0;
	localparam logic [3:0] MODE_BACK = 4'd1;
	localparam logic [3:0] MODE_LEFT = 4'd2;
	localparam logic [3:0] MODE_RIGHT = 4'd3;
	localparam logic [3:0] MODE_UP = 4'd4;
	localparam logic [3:0] MODE_DOWN = 4'd5;
	localparam logic [3:0] MODE_TRN_R = 4'd6;
	localparam logic [3:0] MODE_TRN_L = 4'd7;
	localparam logic [3:0] MODE_TRN_U = 4'd8;
	localparam logic [3:0] MODE_TRN_D = 4'd9;
	localparam logic [3:0] MODE_TRN_CW = 4'd10;
	localparam logic [3:0] MODE_TRN_CCW = 4'd11;
	localparam logic [3:0] MODE_SET_POS = 4'd12;
	localparam logic [3:0] MODE_SET_ORI = 4'd13;

	localparam logic [1:0] REG_MOVE_STEP = 2'd0;
	localparam logic [1:0] REG_COS_STEP = 2'd1;
	localparam logic [1:0] REG_SIN_STEP = 2'd2;

	typedef struct packed {
		logic [3:0] mode;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] dir_in_x;
		logic signed [15:0] dir_in_y;
		logic signed [15:0] dir_in_z;
		logic signed [15:0] up_in_x;
		logic signed [15:0] up_in_y;
		logic signed [15:0] up_in_z;
	} cmd_t;

	typedef struct packed {
		logic signed [15:0] right_x;
		logic signed [15:0] right_y;
		logic signed [15:0] right_z;
		logic signed [15:0] upv_x;
		logic signed [15:0] upv_y;
		logic signed [15:0] upv_z;
		logic signed [15:0] dirv_x;
		logic signed [15:0] dirv_y;
		logic signed [15:0] dirv_z;
		logic signed [31:0] trans_x;
		logic signed [31:0] trans_y;
		logic signed [31:0] trans_z;
	} view_t;

	typedef struct packed {
		logic [1:0] index;
		logic [15:0] data;
	} cfg_t;

	// Command to the shared multiply-accumulate unit.
	typedef struct packed {
		logic clr;
		logic acc;
		logic sub;
		logic signed [31:0] a;
		logic signed [15:0] b;
	} mac_cmd_t;
endpackage

// File: sv/fcpu_if.sv
// Valid/ready channel interfaces for command, view and configuration items.
// Depends on fcpu_pkg.
`timescale 1ns / 1ps
interface fcpu_cmd_if;
	logic valid;
	logic ready;
	fcpu_pkg::cmd_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface fcpu_view_if;
	logic valid;
	logic ready;
	fcpu_pkg::view_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface fcpu_cfg_if;
	logic valid;
	logic ready;
	fcpu_pkg::cfg_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: sv/fly_camera_pose_update.sv
// Fly camera pose: the block accepts a command item, runs the sequencer steps on the single
// shared 32x16 multiply-accumulate unit (nine groups of three product slots and a write-back
// slot: move or turn, cross product, then translations; every mode runs all nine), presents the
// view item until it is taken, and only then, on the cycle after, accepts the next command.
// Depends on fcpu_pkg, fcpu_if and fcpu_mac.
`timescale 1ns / 1ps
module fly_camera_pose_update (
	input logic clk,
	input logic arst_n,
	fcpu_cmd_if.sink cmd,
	fcpu_cfg_if.sink cfg,
	fcpu_view_if.source view
);
	import fcpu_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN = 3'b010,
		ST_OUT = 3'b100
	} state_t;

	// Sequencer step: one micro-op each, with the accumulator result
	// of the previous op visible in the next step.
	localparam int NSTEP = 36;

	state_t state_q;
	logic [5:0] step_q;
	logic [3:0] mode_q;
	logic [15:0] move_step_q;
	logic signed [15:0] cos_q, sin_q;
	logic signed [31:0] pos_q [3];
	logic signed [15:0] dir_q [3];
	logic signed [15:0] up_q [3];
	logic signed [15:0] rgt_q [3];
	logic signed [31:0] trn_q [3];

	mac_cmd_t mc;
	logic mac_en;
	logic signed [63:0] acc;

	fcpu_mac u_mac (.clk(clk), .en(mac_en), .cmd(mc), .acc(acc));

	// Step plan: each result component uses a 4-step group: products in
	// slots 0, 1 and 2, and the sum written back in slot 3.
	logic [3:0] grp;
	logic [1:0] slot;
	assign grp = step_q[5:2];
	assign slot = step_q[1:0];

	logic is_move, is_rot, has_cross;
	assign is_move = (mode_q <= MODE_DOWN);
	assign is_rot = (mode_q >= MODE_TRN_R) && (mode_q <= MODE_TRN_CCW);
	assign has_cross = is_rot || (mode_q == MODE_SET_ORI);

	// Axis chosen for move and rotation operands.
	logic signed [15:0] mv_ax [3];
	logic mv_neg;
	logic signed [15:0] rv [3];
	logic signed [15:0] rw [3];
	logic rsub;
	always_comb begin
		mv_neg = 1'b0;
		rsub = 1'b0;
		for (int i = 0; i < 3; i++) begin
			mv_ax[i] = dir_q[i];
			rv[i] = dir_q[i];
			rw[i] = rgt_q[i];
		end
		case (mode_q)
			MODE_FRONT: mv_neg = 1'b1;
			MODE_BACK: mv_neg = 1'b0;
			MODE_LEFT: begin mv_neg = 1'b1; for (int i = 0; i < 3; i++) mv_ax[i] = rgt_q[i]; end
			MODE_RIGHT: for (int i = 0; i < 3; i++) mv_ax[i] = rgt_q[i];
			MODE_UP: for (int i = 0; i < 3; i++) mv_ax[i] = up_q[i];
			MODE_DOWN: begin mv_neg = 1'b1; for (int i = 0; i < 3; i++) mv_ax[i] = up_q[i]; end
			MODE_TRN_R: rsub = 1'b1;
			MODE_TRN_L: rsub = 1'b0;
			MODE_TRN_U: begin rsub = 1'b1; for (int i = 0; i < 3; i++) rw[i] = up_q[i]; end
			MODE_TRN_D: for (int i = 0; i < 3; i++) rw[i] = up_q[i];
			MODE_TRN_CW: for (int i = 0; i < 3; i++) rv[i] = up_q[i];
			MODE_TRN_CCW: begin
				rsub = 1'b1;
				for (int i = 0; i < 3; i++) rv[i] = up_q[i];
			end
			default: ;
		endcase
	end

	// Cross product operands r = a x b; updating up for turn up/down.
	logic cr_up;
	logic signed [15:0] ca [3];
	logic signed [15:0] cb [3];
	always_comb begin
		cr_up = (mode_q == MODE_TRN_U) || (mode_q == MODE_TRN_D);
		for (int i = 0; i < 3; i++) begin
			ca[i] = cr_up ? dir_q[i] : up_q[i];
			cb[i] = cr_up ? rgt_q[i] : dir_q[i];
		end
	end

	// Groups: 0..2 phase A component, 3..5 cross component, 6..8 translation row.
	// Slot 3 of group 8 writes back the last translation.
	logic [1:0] ci;
	logic [1:0] c1, c2;
	always_comb begin
		ci = 2'd0;
		case (grp)
			4'd0, 4'd3, 4'd6: ci = 2'd0;
			4'd1, 4'd4, 4'd7: ci = 2'd1;
			4'd2, 4'd5, 4'd8: ci = 2'd2;
			default: ci = 2'd0;
		endcase
		c1 = (ci == 2'd2) ? 2'd0 : ci + 2'd1;
		c2 = (ci == 2'd0) ? 2'd2 : ci - 2'd1;
	end

	logic signed [15:0] tax [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			case (grp)
				4'd6: tax[i] = rgt_q[i];
				4'd7: tax[i] = up_q[i];
				default: tax[i] = dir_q[i];
			endcase
		end
	end

	always_comb begin
		mc = '0;
		mac_en = 1'b0;
		if (state_q == ST_RUN && slot != 2'd3) begin
			mac_en = 1'b1;
			mc.clr = (slot == 2'd0);
			if (grp <= 4'd2) begin
				if (is_move) begin
					mc.a = 32'(signed'({1'b0, move_step_q}));
					mc.b = (slot == 2'd0) ? mv_ax[ci] : 16'sd0;
				end else begin
					mc.a = 32'((slot == 2'd0) ? cos_q : sin_q);
					mc.b = (slot == 2'd0) ? rv[ci] : (slot == 2'd1 ? rw[ci] : 16'sd0);
					mc.sub = (slot == 2'd1) && rsub;
				end
			end else if (grp <= 4'd5) begin
				mc.a = 32'((slot == 2'd0) ? ca[c1] : ca[c2]);
				mc.b = (slot == 2'd0) ? cb[c2] : (slot == 2'd1 ? cb[c1] : 16'sd0);
				mc.sub = (slot == 2'd1);
			end else if (grp <= 4'd8) begin
				mc.a = pos_q[slot];
				mc.b = tax[slot];
				mc.sub = 1'b1;
			end
		end
	end

	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		if (v > 64'sd32767) return 16'sh7fff;
		if (v < -64'sd32768) return -16'sh8000;
		return v[15:0];
	endfunction
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	logic signed [63:0] mv_sum;
	logic signed [63:0] sh14;
	assign sh14 = acc >>> 14;
	always_comb begin
		if (mv_neg) mv_sum = 64'(pos_q[ci]) - (acc >>> 6);
		else mv_sum = 64'(pos_q[ci]) + (acc >>> 6);
	end

	assign cmd.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign view.valid = (state_q == ST_OUT);
	assign view.data.right_x = rgt_q[0];
	assign view.data.right_y = rgt_q[1];
	assign view.data.right_z = rgt_q[2];
	assign view.data.upv_x = up_q[0];
	assign view.data.upv_y = up_q[1];
	assign view.data.upv_z = up_q[2];
	assign view.data.dirv_x = dir_q[0];
	assign view.data.dirv_y = dir_q[1];
	assign view.data.dirv_z = dir_q[2];
	assign view.data.trans_x = trn_q[0];
	assign view.data.trans_y = trn_q[1];
	assign view.data.trans_z = trn_q[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			mode_q <= '0;
			move_step_q <= 16'd26;
			cos_q <= 16'sd16382;
			sin_q <= 16'sd286;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				dir_q[i] <= '0;
				up_q[i] <= '0;
				rgt_q[i] <= '0;
				trn_q[i] <= '0;
			end
			dir_q[2] <= 16'sd16384;
			up_q[1] <= 16'sd16384;
			rgt_q[0] <= 16'sd16384;
		end else begin
			if (cfg.valid) begin
				case (cfg.data.index)
					REG_MOVE_STEP: move_step_q <= cfg.data.data;
					REG_COS_STEP: cos_q <= cfg.data.data;
					REG_SIN_STEP: sin_q <= cfg.data.data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						mode_q <= cmd.data.mode;
						step_q <= '0;
						state_q <= ST_RUN;
						if (cmd.data.mode == MODE_SET_POS) begin
							pos_q[0] <= cmd.data.pos_x;
							pos_q[1] <= cmd.data.pos_y;
							pos_q[2] <= cmd.data.pos_z;
						end
						if (cmd.data.mode == MODE_SET_ORI) begin
							dir_q[0] <= cmd.data.dir_in_x;
							dir_q[1] <= cmd.data.dir_in_y;
							dir_q[2] <= cmd.data.dir_in_z;
							up_q[0] <= cmd.data.up_in_x;
							up_q[1] <= cmd.data.up_in_y;
							up_q[2] <= cmd.data.up_in_z;
						end
					end
				end
				ST_RUN: begin
					// Write back at slot 3 of each group; accumulator holds the sum.
					if (slot == 2'd3) begin
						if (grp <= 4'd2) begin
							if (is_move) pos_q[ci] <= sat32(mv_sum);
							else if (is_rot) begin
								if (mode_q >= MODE_TRN_CW) up_q[ci] <= sat16(sh14);
								else dir_q[ci] <= sat16(sh14);
							end
						end else if (grp <= 4'd5) begin
							// Cross results are held in trn_q and applied together with the last one.
							if (has_cross) trn_q[ci] <= 32'(sat16(sh14));
						end else begin
							trn_q[ci] <= sat32(sh14);
						end
						if (grp == 4'd5 && has_cross) begin
							for (int i = 0; i < 3; i++) begin
								if (cr_up) begin
									up_q[i] <= (i == 2) ? sat16(sh14) : trn_q[i][15:0];
								end else begin
									rgt_q[i] <= (i == 2) ? sat16(sh14) : trn_q[i][15:0];
								end
							end
						end
					end
					if (step_q == 6'(NSTEP - 1)) state_q <= ST_OUT;
					else step_q <= step_q + 6'd1;
				end
				ST_OUT: begin
					if (view.ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: sv/fcpu_mac.sv
// Shared signed multiply-accumulate unit, 32x16 product into a 64-bit sum.
// Depends on fcpu_pkg.
`timescale 1ns / 1ps
module fcpu_mac (
	input logic clk,
	input logic en,
	input fcpu_pkg::mac_cmd_t cmd,
	output logic signed [63:0] acc
);
	import fcpu_pkg::*;
	logic signed [47:0] prod;
	logic signed [63:0] acc_q;
	logic signed [63:0] base;

	assign prod = cmd.a * cmd.b;
	assign base = cmd.clr ? 64'sd0 : acc_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (cmd.sub) acc_q <= base - 64'(prod);
			else acc_q <= base + 64'(prod);
		end
	end
	assign acc = acc_q;
endmodule

// File: sv/fcpu_checker.sv
// Port-level checker for the fly camera pose block, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fcpu_checker (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic view_valid,
	input logic view_ready
);
	`CHK_NEXT(a_busy_after_accept, clk, arst_n, cmd_valid && cmd_ready, !cmd_ready)
	`CHK_IMPL(a_no_overlap, clk, arst_n, view_valid, !cmd_ready)
	`CHK_NEXT(a_view_holds, clk, arst_n, view_valid && !view_ready, view_valid)
	`CHK_NEXT(a_accept_no_view, clk, arst_n, cmd_valid && cmd_ready, !view_valid)
endmodule

bind fly_camera_pose_update fcpu_checker u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.cmd_valid(cmd.valid),
	.cmd_ready(cmd.ready),
	.view_valid(view.valid),
	.view_ready(view.ready)
);

// File: bench/fly_camera_pose_update_tb.sv
// Self-checking bench for the fly camera pose block: random command and
// configuration traffic with a built-in pose predictor.
// Depends on fcpu_pkg, fcpu_if and the block itself.
`timescale 1ns / 1ps
module fly_camera_pose_update_tb;
	import fcpu_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fcpu_cmd_if cmd_ch();
	fcpu_cfg_if cfg_ch();
	fcpu_view_if view_ch();

	fly_camera_pose_update dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch.sink),
		.cfg(cfg_ch.sink),
		.view(view_ch.source)
	);

	always #10 clk = ~clk;

	// Predicted pose and registers.
	logic signed [31:0] cam_pos [3];
	logic signed [15:0] cam_dir [3];
	logic signed [15:0] cam_up [3];
	logic signed [15:0] cam_right [3];
	logic [15:0] step_len;
	logic signed [15:0] turn_cos;
	logic signed [15:0] turn_sin;

	cmd_t pending_cmds [$];
	view_t expected_views [$];
	int error_count = 0;
	int views_seen = 0;
	int cycle_count = 0;
	bit stim_done = 1'b0;

	function automatic logic signed [15:0] clamp16(longint v);
		if (v > 32767) return 16'sd32767;
		if (v < -32768) return -16'sd32768;
		return v[15:0];
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	task automatic move_along(input logic signed [15:0] ax [3], input bit neg);
		longint d;
		for (int i = 0; i < 3; i++) begin
			d = (longint'($signed({1'b0, step_len})) * longint'(ax[i])) >>> 6;
			cam_pos[i] = clamp32(neg ? longint'(cam_pos[i]) - d : longint'(cam_pos[i]) + d);
		end
	endtask

	task automatic rotate_vec(inout logic signed [15:0] v [3],
			input logic signed [15:0] w [3], input bit minus);
		longint a, b;
		for (int i = 0; i < 3; i++) begin
			a = longint'(turn_cos) * longint'(v[i]);
			b = longint'(turn_sin) * longint'(w[i]);
			v[i] = clamp16((minus ? a - b : a + b) >>> 14);
		end
	endtask

	task automatic cross_vec(output logic signed [15:0] r [3],
			input logic signed [15:0] a [3], input logic signed [15:0] b [3]);
		r[0] = clamp16((longint'(a[1]) * b[2] - longint'(a[2]) * b[1]) >>> 14);
		r[1] = clamp16((longint'(a[2]) * b[0] - longint'(a[0]) * b[2]) >>> 14);
		r[2] = clamp16((longint'(a[0]) * b[1] - longint'(a[1]) * b[0]) >>> 14);
	endtask

	function automatic logic signed [31:0] translation(input logic signed [15:0] ax [3]);
		longint s;
		s = 0;
		for (int i = 0; i < 3; i++) s += longint'(ax[i]) * longint'(cam_pos[i]);
		return clamp32((-s) >>> 14);
	endfunction

	task automatic predict_view(input cmd_t c);
		view_t v;
		case (c.mode)
			MODE_FRONT: move_along(cam_dir, 1'b1);
			MODE_BACK: move_along(cam_dir, 1'b0);
			MODE_LEFT: move_along(cam_right, 1'b1);
			MODE_RIGHT: move_along(cam_right, 1'b0);
			MODE_UP: move_along(cam_up, 1'b0);
			MODE_DOWN: move_along(cam_up, 1'b1);
			MODE_TRN_R: begin
				rotate_vec(cam_dir, cam_right, 1'b1);
				cross_vec(cam_right, cam_up, cam_dir);
			end
			MODE_TRN_L: begin
				rotate_vec(cam_dir, cam_right, 1'b0);
				cross_vec(cam_right, cam_up, cam_dir);
			end
			MODE_TRN_U: begin
				rotate_vec(cam_dir, cam_up, 1'b1);
				cross_vec(cam_up, cam_dir, cam_right);
			end
			MODE_TRN_D: begin
				rotate_vec(cam_dir, cam_up, 1'b0);
				cross_vec(cam_up, cam_dir, cam_right);
			end
			MODE_TRN_CW: begin
				rotate_vec(cam_up, cam_right, 1'b0);
				cross_vec(cam_right, cam_up, cam_dir);
			end
			MODE_TRN_CCW: begin
				rotate_vec(cam_up, cam_right, 1'b1);
				cross_vec(cam_right, cam_up, cam_dir);
			end
			MODE_SET_POS: begin
				cam_pos[0] = c.pos_x;
				cam_pos[1] = c.pos_y;
				cam_pos[2] = c.pos_z;
			end
			MODE_SET_ORI: begin
				cam_dir[0] = c.dir_in_x;
				cam_dir[1] = c.dir_in_y;
				cam_dir[2] = c.dir_in_z;
				cam_up[0] = c.up_in_x;
				cam_up[1] = c.up_in_y;
				cam_up[2] = c.up_in_z;
				cross_vec(cam_right, cam_up, cam_dir);
			end
			default: ;
		endcase
		v.right_x = cam_right[0];
		v.right_y = cam_right[1];
		v.right_z = cam_right[2];
		v.upv_x = cam_up[0];
		v.upv_y = cam_up[1];
		v.upv_z = cam_up[2];
		v.dirv_x = cam_dir[0];
		v.dirv_y = cam_dir[1];
		v.dirv_z = cam_dir[2];
		v.trans_x = translation(cam_right);
		v.trans_y = translation(cam_up);
		v.trans_z = translation(cam_dir);
		expected_views.push_back(v);
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch on view item %0d, %s: got %0d, expected %0d",
			views_seen, what, got, want);
		error_count++;
	endtask

	function automatic int gap_len();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	// Command accept, seen at the rising edge, feeds the predictor.
	bit cmd_fire = 1'b0;
	always @(posedge clk) begin
		cmd_fire <= cmd_ch.valid && cmd_ch.ready;
		if (cmd_ch.valid && cmd_ch.ready) predict_view(cmd_ch.data);
	end

	// Command driver.
	int cmd_gap = 0;
	always @(negedge clk) begin
		if (cmd_fire) begin
			cmd_gap <= gap_len();
			cmd_ch.valid <= 1'b0;
		end else if (!cmd_ch.valid && arst_n) begin
			if (cmd_gap > 0) begin
				cmd_gap <= cmd_gap - 1;
			end else if (pending_cmds.size() > 0) begin
				cmd_ch.data <= pending_cmds.pop_front();
				cmd_ch.valid <= 1'b1;
			end
		end
	end

	// View monitor with random back-pressure.
	int view_stall = 0;
	always @(posedge clk) begin
		view_t got, want;
		cycle_count++;
		if (view_ch.valid && view_ch.ready) begin
			got = view_ch.data;
			if (expected_views.size() == 0) begin
				$display("view item %0d arrived with nothing expected", views_seen);
				error_count++;
			end else begin
				want = expected_views.pop_front();
				if (got.right_x !== want.right_x) report_mismatch("right_x", got.right_x, want.right_x);
				if (got.right_y !== want.right_y) report_mismatch("right_y", got.right_y, want.right_y);
				if (got.right_z !== want.right_z) report_mismatch("right_z", got.right_z, want.right_z);
				if (got.upv_x !== want.upv_x) report_mismatch("upv_x", got.upv_x, want.upv_x);
				if (got.upv_y !== want.upv_y) report_mismatch("upv_y", got.upv_y, want.upv_y);
				if (got.upv_z !== want.upv_z) report_mismatch("upv_z", got.upv_z, want.upv_z);
				if (got.dirv_x !== want.dirv_x) report_mismatch("dirv_x", got.dirv_x, want.dirv_x);
				if (got.dirv_y !== want.dirv_y) report_mismatch("dirv_y", got.dirv_y, want.dirv_y);
				if (got.dirv_z !== want.dirv_z) report_mismatch("dirv_z", got.dirv_z, want.dirv_z);
				if (got.trans_x !== want.trans_x) report_mismatch("trans_x", got.trans_x, want.trans_x);
				if (got.trans_y !== want.trans_y) report_mismatch("trans_y", got.trans_y, want.trans_y);
				if (got.trans_z !== want.trans_z) report_mismatch("trans_z", got.trans_z, want.trans_z);
			end
			views_seen++;
		end
		if (cycle_count > 1000000) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (view_stall > 0) begin
			view_stall <= view_stall - 1;
			view_ch.ready <= 1'b0;
		end else if (!stim_done && $urandom_range(0, 4) == 0) begin
			view_stall <= gap_len();
			view_ch.ready <= 1'b0;
		end else begin
			view_ch.ready <= 1'b1;
		end
	end

	function automatic cmd_t rand_cmd(input logic [3:0] m);
		cmd_t c;
		logic [223:0] r;
		r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		c = r[$bits(cmd_t)-1:0];
		c.mode = m;
		// Mostly sane poses so the turns and moves stay off the rails.
		if (m == MODE_SET_POS && $urandom_range(0, 3) != 0) begin
			c.pos_x = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
			c.pos_y = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
			c.pos_z = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
		end
		if (m == MODE_SET_ORI && $urandom_range(0, 2) != 0) begin
			c.dir_in_x = 16'sd0;
			c.dir_in_y = 16'sd0;
			c.dir_in_z = 16'sd16384;
			c.up_in_x = 16'sd0;
			c.up_in_y = 16'sd16384;
			c.up_in_z = 16'sd0;
		end
		return c;
	endfunction

	task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_ch.data.index <= idx;
		cfg_ch.data.data <= val;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_MOVE_STEP: step_len = val;
			REG_COS_STEP: turn_cos = val;
			default: turn_sin = val;
		endcase
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		while ((pending_cmds.size() > 0 || cmd_ch.valid || expected_views.size() > 0)
				&& guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (40) @(posedge clk);
	endtask

	task automatic run_phase(input int count);
		for (int i = 0; i < count; i++)
			pending_cmds.push_back(rand_cmd(4'($urandom_range(0, 15))));
		drain();
	endtask

	cmd_t c;
	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		view_ch.ready = 1'b0;
		for (int i = 0; i < 3; i++) begin
			cam_pos[i] = 0;
			cam_dir[i] = 0;
			cam_up[i] = 0;
			cam_right[i] = 0;
		end
		cam_dir[2] = 16384;
		cam_up[1] = 16384;
		cam_right[0] = 16384;
		step_len = 16'd26;
		turn_cos = 16'sd16382;
		turn_sin = 16'sd286;
		repeat (8) @(posedge clk);
		arst_n = 1'b1;

		// Directed: every mode at reset settings, then the field extremes.
		for (int m = 0; m < 16; m++) pending_cmds.push_back(rand_cmd(m[3:0]));
		c = '0;
		c.mode = MODE_SET_POS;
		c.pos_x = 32'sh7fffffff;
		c.pos_y = 32'sh80000000;
		c.pos_z = 32'sh7fffffff;
		pending_cmds.push_back(c);
		c.mode = MODE_BACK;
		pending_cmds.push_back(c);
		c.mode = MODE_SET_ORI;
		c.dir_in_x = 16'sh7fff;
		c.dir_in_y = 16'sh8000;
		c.dir_in_z = 16'sh7fff;
		c.up_in_x = 16'sh8000;
		c.up_in_y = 16'sh7fff;
		c.up_in_z = 16'sh8000;
		pending_cmds.push_back(c);
		c.mode = MODE_FRONT;
		pending_cmds.push_back(c);
		c.mode = MODE_TRN_R;
		pending_cmds.push_back(c);
		c.mode = MODE_TRN_CW;
		pending_cmds.push_back(c);
		drain();

		// Register extremes, out-of-range turn values included.
		cfg_write(REG_MOVE_STEP, 16'hffff);
		cfg_write(REG_COS_STEP, 16'h8000);
		cfg_write(REG_SIN_STEP, 16'h7fff);
		run_phase(150);
		cfg_write(REG_MOVE_STEP, 16'h0000);
		cfg_write(REG_COS_STEP, 16'h4000);
		cfg_write(REG_SIN_STEP, 16'hc000);
		run_phase(150);
		for (int p = 0; p < 5; p++) begin
			cfg_write(REG_MOVE_STEP, 16'($urandom));
			cfg_write(REG_COS_STEP, 16'($urandom_range(0, 32768) - 16384));
			cfg_write(REG_SIN_STEP, 16'($urandom_range(0, 32768) - 16384));
			run_phase(150);
		end
		stim_done = 1'b1;
		drain();

		$display("covered %0d view items across eight register settings", views_seen);
		$display("all sixteen mode codes and the field extremes were exercised");
		if (error_count == 0 && expected_views.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

// File: fly_camera_pose_update.f
+incdir+sv
sv/fcpu_pkg.sv
sv/fcpu_if.sv
sv/fcpu_mac.sv
sv/fly_camera_pose_update.sv
sv/fcpu_checker.sv
bench/fly_camera_pose_update_tb.sv
